/* hw/rtl/ilie_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_pkg: shared types and codes for the indexed list
// Request/response structs, operation and status codes, cell command.
// ----------------------------------------------------------------------------
package ilie_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int CNT_W      = 5;                // count/index field width
	localparam int POS_W      = $clog2(DEPTH);    // cell address width

	typedef logic [2:0] mode_t;
	localparam mode_t MODE_READ   = 3'd0;
	localparam mode_t MODE_PUSH   = 3'd1;
	localparam mode_t MODE_POP    = 3'd2;
	localparam mode_t MODE_CLEAR  = 3'd3;
	localparam mode_t MODE_ERASE  = 3'd4;
	localparam mode_t MODE_INSERT = 3'd5;

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_FULL  = 2'd1;
	localparam status_t ST_RANGE = 2'd2;
	localparam status_t ST_EMPTY = 2'd3;

	typedef logic [1:0] cell_op_t;
	localparam cell_op_t CELL_HOLD = 2'd0;
	localparam cell_op_t CELL_INS  = 2'd1;
	localparam cell_op_t CELL_ERA  = 2'd2;

	typedef struct packed {
		mode_t                         mode;
		logic [CNT_W-1:0]              index;
		logic signed [DATA_WIDTH-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0]  read_data;
		logic [CNT_W-1:0]              entry_count;
		status_t                       status;
	} rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		cell_op_t                      kind;
		logic [CNT_W-1:0]              index;
		logic [CNT_W-1:0]              fill;
		logic signed [DATA_WIDTH-1:0]  value;
	} cmd_t;

endpackage
`default_nettype wire

/* hw/rtl/indexed_list_insert_erase.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// indexed_list_insert_erase: bounded ordered list with insert and erase
// Row of entry cells that shift in parallel; one response per request.
// ----------------------------------------------------------------------------
// Response: a request's response is registered and is valid in the cycle
//   after the request is taken. Throughput: one request per cycle; every
//   operation, even a full insert or erase shift, is done by all cells moving
//   together. A response held by rsp_stall holds off the next request.
// Reset: arst_n clears the entry count and the response valid; entry
//   contents are not reset and are only read below the count.
module indexed_list_insert_erase (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            req_valid,
	output logic                 req_stall,
	input  wire ilie_pkg::req_t  req,
	output logic                 rsp_valid,
	input  wire logic            rsp_stall,
	output ilie_pkg::rsp_t       rsp
);
	import ilie_pkg::*;

	logic [CNT_W-1:0]             fill_q;
	logic [CNT_W-1:0]             fill_next;
	logic                         rsp_valid_q;
	rsp_t                         rsp_q;
	logic                         req_take;
	logic                         list_full;
	logic                         list_empty;
	logic                         idx_below;     // index < count
	logic                         idx_above;     // index > count
	status_t                      status;
	logic signed [DATA_WIDTH-1:0] rdata;
	cmd_t                         cmd;
	logic signed [DATA_WIDTH-1:0] words [DEPTH];

	// Output register: a new request is taken unless a response is waiting
	// and stalled.
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_take  = req_valid && !req_stall;

	assign list_full  = (fill_q == CNT_W'(DEPTH));
	assign list_empty = (fill_q == '0);
	assign idx_below  = (req.index < fill_q);
	assign idx_above  = (req.index > fill_q);

	// Decode the operation into status, read data, next count and the cell command.
	// Push is an insert at the current count.
	always_comb begin
		status    = ST_OK;
		fill_next = fill_q;
		rdata     = '0;
		cmd.kind  = CELL_HOLD;
		cmd.index = req.index;
		cmd.fill  = fill_q;
		cmd.value = req.value;
		unique case (req.mode)
			MODE_READ: begin
				if (idx_below) begin
					rdata = words[req.index[POS_W-1:0]];
				end else begin
					status = ST_RANGE;
				end
			end
			MODE_PUSH: begin
				if (list_full) begin
					status = ST_FULL;
				end else begin
					cmd.kind  = CELL_INS;
					cmd.index = fill_q;
					fill_next = fill_q + CNT_W'(1);
				end
			end
			MODE_POP: begin
				if (list_empty) begin
					status = ST_EMPTY;
				end else begin
					fill_next = fill_q - CNT_W'(1);
				end
			end
			MODE_CLEAR: begin
				fill_next = '0;
			end
			MODE_ERASE: begin
				if (!idx_below) begin
					status = ST_RANGE;
				end else begin
					cmd.kind  = CELL_ERA;
					fill_next = fill_q - CNT_W'(1);
				end
			end
			MODE_INSERT: begin
				// fullness wins over a bad index
				if (list_full) begin
					status = ST_FULL;
				end else if (idx_above) begin
					status = ST_RANGE;
				end else begin
					cmd.kind  = CELL_INS;
					fill_next = fill_q + CNT_W'(1);
				end
			end
			default: begin
				status = ST_OK;
			end
		endcase
		// cells only move on a taken request
		if (!req_take) begin
			cmd.kind = CELL_HOLD;
		end
	end

	// Chain of cells: each sees its neighbors; the ends see zero.
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic signed [DATA_WIDTH-1:0] left_w;
		logic signed [DATA_WIDTH-1:0] right_w;
		if (g == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = words[g-1];
		end
		if (g == DEPTH-1) begin : g_last
			assign right_w = '0;
		end else begin : g_mid_r
			assign right_w = words[g+1];
		end
		ilie_cell u_cell (
			.clk        (clk),
			.cell_pos   (CNT_W'(g)),
			.cmd        (cmd),
			.left_word  (left_w),
			.right_word (right_w),
			.word       (words[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (req_take) begin
				fill_q <= fill_next;
			end
			if (req_take) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, no reset
	always_ff @(posedge clk) begin
		if (req_take) begin
			rsp_q.read_data   <= rdata;
			rsp_q.entry_count <= fill_next;
			rsp_q.status      <= status;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

/* hw/rtl/ilie_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_cell: one list entry
// Holds one word; loads the new value, its left or its right neighbor.
// ----------------------------------------------------------------------------
module ilie_cell (
	input  wire logic                                  clk,
	input  wire logic [ilie_pkg::CNT_W-1:0]            cell_pos,
	input  wire ilie_pkg::cmd_t                        cmd,
	input  wire logic signed [ilie_pkg::DATA_WIDTH-1:0] left_word,
	input  wire logic signed [ilie_pkg::DATA_WIDTH-1:0] right_word,
	output logic signed [ilie_pkg::DATA_WIDTH-1:0]      word
);
	import ilie_pkg::*;

	logic signed [DATA_WIDTH-1:0] word_q;
	logic signed [DATA_WIDTH-1:0] next_word;
	logic [CNT_W:0]               pos_plus1;

	assign pos_plus1 = {1'b0, cell_pos} + (CNT_W+1)'(1);

	always_comb begin
		next_word = word_q;
		unique case (cmd.kind)
			CELL_INS: begin
				if (cell_pos == cmd.index) begin
					next_word = cmd.value;
				end else if (cell_pos > cmd.index && cell_pos <= cmd.fill) begin
					next_word = left_word;
				end
			end
			CELL_ERA: begin
				// entries above the hole move down one place
				if (cell_pos >= cmd.index && pos_plus1 < {1'b0, cmd.fill}) begin
					next_word = right_word;
				end
			end
			default: begin
				next_word = word_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		word_q <= next_word;
	end

	assign word = word_q;

endmodule
`default_nettype wire

/* hw/rtl/ilie_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilie_checker: port-level checks for the indexed list
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module ilie_checker (
	input wire logic            clk,
	input wire logic            arst_n,
	input wire logic            req_valid,
	input wire logic            req_stall,
	input wire ilie_pkg::req_t  req,
	input wire logic            rsp_valid,
	input wire logic            rsp_stall,
	input wire ilie_pkg::rsp_t  rsp
);
	import ilie_pkg::*;

	// stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("stalled response changed");

	// every taken request answers in the next cycle
	a_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> rsp_valid)
		else $error("no response after taken request");

	// clear always empties the list
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall && req.mode == MODE_CLEAR
		|=> rsp.entry_count == '0 && rsp.status == ST_OK)
		else $error("clear did not empty list");

	// count never exceeds capacity; failed ops return zero data
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> rsp.entry_count <= CNT_W'(DEPTH)
			&& (rsp.status == ST_OK || rsp.read_data == '0))
		else $error("bad count or data on response");

endmodule

bind indexed_list_insert_erase ilie_checker u_ilie_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
`default_nettype wire
